>>> design/hem_pkg.sv
package hem_pkg;

  // Store sizes
  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W       = $clog2(MAT_DEPTH);

  // Fixed field widths of the channels
  localparam int OPC_W      = 2;
  localparam int FIELD_V_W  = 5;
  localparam int FIELD_WT_W = 16;
  localparam int FIELD_GC_W = 6;
  localparam int CFG_W      = 6;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_ORDER  = 2'd1,
    OP_RUN         = 2'd2
  } hem_op_e;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic              clear;
    logic [VIDX_W-1:0] seed;
    logic              valid;
    logic              skip;
    logic [VIDX_W-1:0] idx;
  } hem_cmp_t;

  // Matrix address of row r, column c
  function automatic logic [ADDR_W-1:0] mat_addr(logic [VIDX_W-1:0] r,
                                                 logic [VIDX_W-1:0] c);
    logic [ADDR_W-1:0] res;
    res = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_VERTICES)) + ADDR_W'(c);
    return res;
  endfunction

  // Field value addresses a vertex inside the stores
  function automatic logic in_store(logic [FIELD_V_W-1:0] x);
    logic res;
    res = (32'(x) < 32'(MAX_VERTICES));
    return res;
  endfunction

endpackage

>>> design/hem_in_if.sv
interface hem_in_if;
  logic                               valid;
  logic                               ready;
  logic [hem_pkg::OPC_W-1:0]          opcode;
  logic [hem_pkg::FIELD_V_W-1:0]      vertex_a;
  logic [hem_pkg::FIELD_V_W-1:0]      vertex_b;
  logic [hem_pkg::FIELD_WT_W-1:0]     edge_weight;

  modport source(output valid, output opcode, output vertex_a, output vertex_b,
                 output edge_weight, input ready);
  modport sink(input valid, input opcode, input vertex_a, input vertex_b,
               input edge_weight, output ready);
endinterface

>>> design/hem_out_if.sv
interface hem_out_if;
  logic                               valid;
  logic                               ready;
  logic [hem_pkg::FIELD_V_W-1:0]      vertex;
  logic [hem_pkg::FIELD_V_W-1:0]      partner;
  logic [hem_pkg::FIELD_V_W-1:0]      group;
  logic [hem_pkg::FIELD_GC_W-1:0]     group_count;
  logic                               last;

  modport source(output valid, output vertex, output partner, output group,
                 output group_count, output last, input ready);
  modport sink(input valid, input vertex, input partner, input group,
               input group_count, input last, output ready);
endinterface

>>> design/hem_cfg_if.sv
interface hem_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hem_pkg::CFG_W-1:0]     vertex_count;

  modport source(output valid, output vertex_count, input ready);
  modport sink(input valid, input vertex_count, output ready);
endinterface

>>> design/hem_weight_ram.sv
module hem_weight_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [hem_pkg::ADDR_W-1:0]       waddr_i,
  input  logic [hem_pkg::WEIGHT_BITS-1:0]  wdata_i,
  input  logic                             re_i,
  input  logic [hem_pkg::ADDR_W-1:0]       raddr_i,
  output logic [hem_pkg::WEIGHT_BITS-1:0]  rdata_o
);

  logic [hem_pkg::WEIGHT_BITS-1:0] mem [hem_pkg::MAT_DEPTH];
  logic [hem_pkg::WEIGHT_BITS-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hem_best_unit.sv
module hem_best_unit (
  input  logic                             clk_i,
  input  hem_pkg::hem_cmp_t                ctl_i,
  input  logic [hem_pkg::WEIGHT_BITS-1:0]  rdata_i,
  output logic [hem_pkg::VIDX_W-1:0]       best_idx_o
);

  logic [hem_pkg::WEIGHT_BITS-1:0] best_w_q, best_w_d;
  logic [hem_pkg::VIDX_W-1:0]      best_idx_q, best_idx_d;

  // Seed with the visited vertex, keep the first strictly greater weight
  always_comb begin
    best_w_d   = best_w_q;
    best_idx_d = best_idx_q;
    if (ctl_i.clear) begin
      best_w_d   = '0;
      best_idx_d = ctl_i.seed;
    end else if (ctl_i.valid && !ctl_i.skip && (rdata_i > best_w_q)) begin
      best_w_d   = rdata_i;
      best_idx_d = ctl_i.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    best_w_q   <= best_w_d;
    best_idx_q <= best_idx_d;
  end

  assign best_idx_o = best_idx_q;

endmodule

>>> design/heavy_edge_matching_core.sv
// Channel  | Dir | Modport | Transfer carries
// cfg_i    | in  | sink    | vertex_count register write
// in_i     | in  | sink    | opcode, vertex_a, vertex_b, edge_weight
// out_o    | out | source  | vertex, partner, group, group_count, last
//
// A weight load writes both mirror entries, the first in S_IDLE and the mirror in
// S_LOAD2; an order load writes the visit order store directly. During a run each
// visited vertex reads its matrix row through the single read port of the weight RAM.
// After reset every weight RAM entry is cleared; in_i is not ready then.
// Results leave through one output register; a stalled out_o holds the sequencer.
module heavy_edge_matching_core (
  input  logic clk_i,
  input  logic rst_ni,
  hem_cfg_if.sink   cfg_i,
  hem_in_if.sink    in_i,
  hem_out_if.source out_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LOAD2 = 9'b000000100,
    S_VISIT = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_PAIR  = 9'b001000000,
    S_FILL  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  localparam int VW = hem_pkg::VIDX_W;
  localparam int CW = hem_pkg::CNT_W;
  localparam int AW = hem_pkg::ADDR_W;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [VW-1:0] i_q, i_d, j_q, j_d, v_q, v_d;
  logic [CW-1:0] n_q, n_d, ngrp_q, ngrp_d;
  logic [hem_pkg::CFG_W-1:0] vc_q;

  logic [VW-1:0] lda_q, ldb_q;
  logic [hem_pkg::WEIGHT_BITS-1:0] ldw_q;

  logic [VW-1:0] visit_q   [hem_pkg::MAX_VERTICES];
  logic [VW-1:0] partner_q [hem_pkg::MAX_VERTICES];
  logic [VW-1:0] group_q   [hem_pkg::MAX_VERTICES];
  logic [hem_pkg::MAX_VERTICES-1:0] matched_q;

  hem_pkg::hem_cmp_t cmp_ctl;
  logic cmp_vld_q, cmp_skip_q;
  logic [VW-1:0] cmp_idx_q;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [hem_pkg::WEIGHT_BITS-1:0] wdata, rdata;
  logic [VW-1:0] best_idx;

  logic in_xfer, out_load, flags_clr;
  logic pair_en;
  logic [VW-1:0] pair_a, pair_b;
  logic [VW-1:0] visit_v;
  logic visit_skip, i_last, j_last;

  logic out_vld_q, out_vld_d;
  logic [hem_pkg::FIELD_V_W-1:0] out_vertex_q, out_partner_q, out_group_q;
  logic [hem_pkg::FIELD_GC_W-1:0] out_gcnt_q;
  logic out_last_q;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign visit_v    = visit_q[i_q];
  assign visit_skip = !(CW'(visit_v) < n_q) || matched_q[visit_v];
  assign i_last     = (CW'(i_q) == CW'(n_q - CW'(1)));
  assign j_last     = (CW'(j_q) == CW'(n_q - CW'(1)));
  assign out_load   = (state_q == S_OUT) && (!out_vld_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    i_d       = i_q;
    j_d       = j_q;
    v_d       = v_q;
    n_d       = n_q;
    ngrp_d    = ngrp_q;
    flags_clr = 1'b0;
    pair_en   = 1'b0;
    pair_a    = v_q;
    pair_b    = best_idx;
    we        = 1'b0;
    waddr     = hem_pkg::mat_addr(VW'(in_i.vertex_a), VW'(in_i.vertex_b));
    wdata     = in_i.edge_weight[hem_pkg::WEIGHT_BITS-1:0];
    re        = 1'b0;
    raddr     = hem_pkg::mat_addr(v_q, j_q);
    cmp_ctl   = '{clear: 1'b0, seed: visit_v, valid: cmp_vld_q, skip: cmp_skip_q,
                  idx: cmp_idx_q};
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(hem_pkg::MAT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.opcode)
            hem_pkg::OP_LOAD_WEIGHT: begin
              if (hem_pkg::in_store(in_i.vertex_a) && hem_pkg::in_store(in_i.vertex_b)) begin
                we      = 1'b1;
                state_d = S_LOAD2;
              end
            end
            hem_pkg::OP_RUN: begin
              n_d       = (int'(vc_q) > hem_pkg::MAX_VERTICES) ?
                          CW'(hem_pkg::MAX_VERTICES) : CW'(vc_q);
              ngrp_d    = '0;
              i_d       = '0;
              flags_clr = 1'b1;
              if (vc_q != '0) begin
                state_d = S_VISIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD2: begin
        we      = 1'b1;
        waddr   = hem_pkg::mat_addr(ldb_q, lda_q);
        wdata   = ldw_q;
        state_d = S_IDLE;
      end
      S_VISIT: begin
        if (visit_skip) begin
          i_d     = i_q + VW'(1);
          state_d = i_last ? S_FILL : S_VISIT;
          if (i_last) begin
            i_d = '0;
          end
        end else begin
          cmp_ctl.clear = 1'b1;
          v_d     = visit_v;
          j_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        re  = 1'b1;
        j_d = j_q + VW'(1);
        if (j_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PAIR;
      end
      S_PAIR: begin
        pair_en = 1'b1;
        ngrp_d  = ngrp_q + CW'(1);
        i_d     = i_q + VW'(1);
        state_d = S_VISIT;
        if (i_last) begin
          i_d     = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        pair_a = i_q;
        pair_b = i_q;
        if (!matched_q[i_q]) begin
          pair_en = 1'b1;
          ngrp_d  = ngrp_q + CW'(1);
        end
        i_d = i_q + VW'(1);
        if (i_last) begin
          i_d     = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          i_d = i_q + VW'(1);
          if (i_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid: load on a free slot, drop on transfer
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      v_q       <= '0;
      n_q       <= '0;
      ngrp_q    <= '0;
      vc_q      <= hem_pkg::CFG_W'(32);
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      i_q       <= i_d;
      j_q       <= j_d;
      v_q       <= v_d;
      n_q       <= n_d;
      ngrp_q    <= ngrp_d;
      cmp_vld_q <= (state_q == S_SCAN);
      out_vld_q <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        vc_q <= cfg_i.vertex_count;
      end
    end
  end

  // Match flags: clear at run start, set on each pairing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= '0;
    end else if (flags_clr) begin
      matched_q <= '0;
    end else if (pair_en) begin
      matched_q[pair_a] <= 1'b1;
      matched_q[pair_b] <= 1'b1;
    end
  end

  // Visit order store, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hem_pkg::MAX_VERTICES; k++) begin
        visit_q[k] <= VW'(k);
      end
    end else if (in_xfer && (in_i.opcode == hem_pkg::OP_LOAD_ORDER) &&
                 hem_pkg::in_store(in_i.vertex_a)) begin
      visit_q[VW'(in_i.vertex_a)] <= VW'(in_i.vertex_b);
    end
  end

  // Payload registers: load latch, compare pipe, partner and group tables, output fields
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lda_q <= VW'(in_i.vertex_a);
      ldb_q <= VW'(in_i.vertex_b);
      ldw_q <= in_i.edge_weight[hem_pkg::WEIGHT_BITS-1:0];
    end
    cmp_idx_q  <= j_q;
    cmp_skip_q <= (j_q == v_q) || matched_q[j_q];
    if (pair_en) begin
      partner_q[pair_a] <= pair_b;
      partner_q[pair_b] <= pair_a;
      group_q[pair_a]   <= ngrp_q[VW-1:0];
      group_q[pair_b]   <= ngrp_q[VW-1:0];
    end
    if (out_load) begin
      out_vertex_q  <= hem_pkg::FIELD_V_W'(i_q);
      out_partner_q <= hem_pkg::FIELD_V_W'(partner_q[i_q]);
      out_group_q   <= hem_pkg::FIELD_V_W'(group_q[i_q]);
      out_gcnt_q    <= hem_pkg::FIELD_GC_W'(ngrp_q);
      out_last_q    <= i_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.vertex      = out_vertex_q;
  assign out_o.partner     = out_partner_q;
  assign out_o.group       = out_group_q;
  assign out_o.group_count = out_gcnt_q;
  assign out_o.last        = out_last_q;

  hem_weight_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hem_best_unit u_best (
    .clk_i      (clk_i),
    .ctl_i      (cmp_ctl),
    .rdata_i    (rdata),
    .best_idx_o (best_idx)
  );

`ifndef SYNTHESIS
  a_cmp_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> $past(state_q == S_SCAN))
    else $error("compare data without a preceding row read");

  a_pair_unmatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAIR) |-> (!matched_q[best_idx] && !matched_q[v_q]))
    else $error("pairing with an already matched vertex");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("input accepted during weight clearing");

  a_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, out_o.group} < out_o.group_count))
    else $error("group number not below group count");
`endif

endmodule

>>> dv/heavy_edge_matching_core_tb.sv
`timescale 1ns / 100ps

module heavy_edge_matching_core_tb;

  // Opcode value that the block does not decode
  localparam logic [hem_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 225;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [hem_pkg::FIELD_V_W-1:0]  vertex;
    logic [hem_pkg::FIELD_V_W-1:0]  partner;
    logic [hem_pkg::FIELD_V_W-1:0]  group;
    logic [hem_pkg::FIELD_GC_W-1:0] group_count;
    logic                           last;
  } match_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hem_cfg_if cfg_if ();
  hem_in_if  in_if ();
  hem_out_if out_if ();

  heavy_edge_matching_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the block state
  logic [hem_pkg::WEIGHT_BITS-1:0] edge_wt [hem_pkg::MAX_VERTICES][hem_pkg::MAX_VERTICES];
  logic [hem_pkg::FIELD_V_W-1:0]   visit_seq [hem_pkg::MAX_VERTICES];
  logic [hem_pkg::CFG_W-1:0]       vertex_total;

  match_result_t expected_matches[$];

  int  fail_count = 0;
  bit  idle_en    = 1'b1;
  int  hold_left  = 0;
  int  stall_left = 0;

  always #2 clk_i = ~clk_i;

  // Compute the matching of the current graph and queue its results
  function automatic void match_graph();
    int                              n;
    int                              v;
    int                              best;
    int                              groups;
    logic [hem_pkg::WEIGHT_BITS-1:0] best_w;
    bit                              taken [hem_pkg::MAX_VERTICES];
    logic [hem_pkg::FIELD_V_W-1:0]   mate [hem_pkg::MAX_VERTICES];
    logic [hem_pkg::FIELD_V_W-1:0]   grp [hem_pkg::MAX_VERTICES];
    match_result_t                   res;
    n = (vertex_total > hem_pkg::MAX_VERTICES) ? hem_pkg::MAX_VERTICES : int'(vertex_total);
    groups = 0;
    for (int i = 0; i < hem_pkg::MAX_VERTICES; i++) begin
      taken[i] = 1'b0;
      mate[i]  = '0;
      grp[i]   = '0;
    end
    // Ordered pass: heaviest unmatched neighbor, lowest index on a tie
    for (int i = 0; i < n; i++) begin
      v = int'(visit_seq[i]);
      if (v >= n || taken[v]) continue;
      best   = v;
      best_w = '0;
      for (int j = 0; j < n; j++) begin
        if (j == v || taken[j]) continue;
        if (edge_wt[v][j] > best_w) begin
          best_w = edge_wt[v][j];
          best   = j;
        end
      end
      mate[v] = hem_pkg::FIELD_V_W'(best);
      mate[best] = hem_pkg::FIELD_V_W'(v);
      taken[v] = 1'b1;
      taken[best] = 1'b1;
      grp[v] = hem_pkg::FIELD_V_W'(groups);
      grp[best] = hem_pkg::FIELD_V_W'(groups);
      groups++;
    end
    // Vertices never visited stay single, in ascending order
    for (int i = 0; i < n; i++) begin
      if (!taken[i]) begin
        mate[i]  = hem_pkg::FIELD_V_W'(i);
        taken[i] = 1'b1;
        grp[i]   = hem_pkg::FIELD_V_W'(groups);
        groups++;
      end
    end
    for (int i = 0; i < n; i++) begin
      res.vertex      = hem_pkg::FIELD_V_W'(i);
      res.partner     = mate[i];
      res.group       = grp[i];
      res.group_count = hem_pkg::FIELD_GC_W'(groups);
      res.last        = (i + 1 == n);
      expected_matches.push_back(res);
    end
  endfunction

  // Update the shadow state with one accepted command
  function automatic void apply_command(input logic [hem_pkg::OPC_W-1:0] op,
                                        input logic [hem_pkg::FIELD_V_W-1:0] a,
                                        input logic [hem_pkg::FIELD_V_W-1:0] b,
                                        input logic [hem_pkg::FIELD_WT_W-1:0] w);
    case (op)
      hem_pkg::OP_LOAD_WEIGHT: begin
        edge_wt[a][b] = hem_pkg::WEIGHT_BITS'(w);
        edge_wt[b][a] = hem_pkg::WEIGHT_BITS'(w);
      end
      hem_pkg::OP_LOAD_ORDER: begin
        visit_seq[a] = b;
      end
      hem_pkg::OP_RUN: begin
        match_graph();
      end
      default: ;
    endcase
  endfunction

  // Offer one command, optionally after a random gap, and hold until transfer
  task automatic send_cmd(input logic [hem_pkg::OPC_W-1:0] op,
                          input logic [hem_pkg::FIELD_V_W-1:0] a,
                          input logic [hem_pkg::FIELD_V_W-1:0] b,
                          input logic [hem_pkg::FIELD_WT_W-1:0] w);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.vertex_a    <= a;
    in_if.vertex_b    <= b;
    in_if.edge_weight <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_command(op, a, b, w);
  endtask

  // Drop input valid, wait for every pending result, then let the block settle
  task automatic wait_all_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [hem_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    vertex_total = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Output ready: long hold-off first, then random stall bursts
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    match_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: vertex %0d partner %0d", out_if.vertex, out_if.partner);
        fail_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_if.vertex !== want.vertex) begin
          $error("vertex: expected %0d, actual %0d", want.vertex, out_if.vertex);
          fail_count++;
        end
        if (out_if.partner !== want.partner) begin
          $error("partner: expected %0d, actual %0d", want.partner, out_if.partner);
          fail_count++;
        end
        if (out_if.group !== want.group) begin
          $error("group: expected %0d, actual %0d", want.group, out_if.group);
          fail_count++;
        end
        if (out_if.group_count !== want.group_count) begin
          $error("group_count: expected %0d, actual %0d", want.group_count,
                 out_if.group_count);
          fail_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  // Reset values: zero weights, identity order, all vertices single
  task automatic test_reset_state();
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
  endtask

  // Ties, the heaviest and lightest weights, a diagonal load, the unused opcode
  task automatic test_weight_extremes();
    write_vertex_count(6'd4);
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd0, 5'd2, 16'hFFFF);
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd1, 5'd0, 16'hFFFF);
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd2, 5'd2, 16'h8000);
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd3, 5'd1, 16'h0001);
    send_cmd(OP_UNUSED, 5'd3, 5'd2, 16'hFFFF);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
  endtask

  // Out-of-range order entries, repeated vertices, positions beyond the count
  task automatic test_visit_order();
    send_cmd(hem_pkg::OP_LOAD_ORDER, 5'd0, 5'd31, '0);
    send_cmd(hem_pkg::OP_LOAD_ORDER, 5'd1, 5'd3, '0);
    send_cmd(hem_pkg::OP_LOAD_ORDER, 5'd2, 5'd3, '0);
    send_cmd(hem_pkg::OP_LOAD_ORDER, 5'd31, 5'd0, '0);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
  endtask

  // Vertex counts of zero, one, and above the store size
  task automatic test_count_extremes();
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd31, 5'd30, 16'hFFFF);
    wait_all_results();
    write_vertex_count(6'd0);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
    write_vertex_count(6'd1);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
    write_vertex_count(6'd63);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
    write_vertex_count(6'd33);
    send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    wait_all_results();
  endtask

  // Hold the output off while runs keep arriving, so the input stalls
  task automatic test_output_backpressure();
    write_vertex_count(6'd3);
    send_cmd(hem_pkg::OP_LOAD_WEIGHT, 5'd0, 5'd2, 16'd7);
    @(posedge clk_i);
    hold_left = 400;
    for (int k = 0; k < 6; k++) begin
      send_cmd(hem_pkg::OP_RUN, '0, '0, '0);
    end
    // Sender pauses here until the last result has gone out
    wait_all_results();
  endtask

  // Random graphs: mostly well-formed loads and orders, some noise
  task automatic test_random_graphs();
    int                             sent;
    int                             n;
    int                             span;
    int                             pick;
    int                             loads;
    int                             j;
    logic [hem_pkg::CFG_W-1:0]      cnt;
    logic [hem_pkg::FIELD_V_W-1:0]  a;
    logic [hem_pkg::FIELD_V_W-1:0]  b;
    logic [hem_pkg::FIELD_V_W-1:0]  tmp;
    logic [hem_pkg::FIELD_WT_W-1:0] w;
    logic [hem_pkg::FIELD_V_W-1:0]  perm [hem_pkg::MAX_VERTICES];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = (sent > RANDOM_ITEMS - 60) ? 1'b0 : ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      case (pick)
        0:       cnt = 6'd0;
        1:       cnt = 6'd1;
        2:       cnt = hem_pkg::CFG_W'($urandom_range(33, 63));
        3:       cnt = 6'd32;
        4, 5:    cnt = hem_pkg::CFG_W'($urandom_range(9, 16));
        default: cnt = hem_pkg::CFG_W'($urandom_range(2, 8));
      endcase
      write_vertex_count(cnt);
      n = (cnt > hem_pkg::MAX_VERTICES) ? hem_pkg::MAX_VERTICES : int'(cnt);
      span = (n == 0) ? 1 : n;

      // Weight loads inside the active graph, with some stray ones
      loads = $urandom_range(0, 2 * span);
      for (int k = 0; k < loads; k++) begin
        pick = $urandom_range(0, 9);
        a = hem_pkg::FIELD_V_W'($urandom_range(0, span - 1));
        b = hem_pkg::FIELD_V_W'($urandom_range(0, span - 1));
        if (pick < 5) w = hem_pkg::FIELD_WT_W'($urandom_range(0, 4));
        else if (pick < 8) w = hem_pkg::FIELD_WT_W'($urandom);
        else w = '0;
        if (pick == 9) begin
          a = hem_pkg::FIELD_V_W'($urandom_range(0, 31));
          b = hem_pkg::FIELD_V_W'($urandom_range(0, 31));
          w = hem_pkg::FIELD_WT_W'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            send_cmd(OP_UNUSED, a, b, w);
            sent++;
            continue;
          end
        end
        send_cmd(hem_pkg::OP_LOAD_WEIGHT, a, b, w);
        sent++;
      end

      // Visit order: usually a shuffled permutation, sometimes broken
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < n; k++) perm[k] = hem_pkg::FIELD_V_W'(k);
        for (int k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
          send_cmd(hem_pkg::OP_LOAD_ORDER, hem_pkg::FIELD_V_W'(k), perm[k],
                   hem_pkg::FIELD_WT_W'($urandom));
          sent++;
        end
      end else begin
        loads = $urandom_range(1, span);
        for (int k = 0; k < loads; k++) begin
          send_cmd(hem_pkg::OP_LOAD_ORDER, hem_pkg::FIELD_V_W'($urandom_range(0, 31)),
                   hem_pkg::FIELD_V_W'($urandom_range(0, 31)),
                   hem_pkg::FIELD_WT_W'($urandom));
          sent++;
        end
      end

      loads = $urandom_range(1, 2);
      for (int k = 0; k < loads; k++) begin
        send_cmd(hem_pkg::OP_RUN, hem_pkg::FIELD_V_W'($urandom),
                 hem_pkg::FIELD_V_W'($urandom), hem_pkg::FIELD_WT_W'($urandom));
        sent++;
      end
      wait_all_results();
    end
  endtask

  initial begin
    for (int r = 0; r < hem_pkg::MAX_VERTICES; r++) begin
      visit_seq[r] = hem_pkg::FIELD_V_W'(r);
      for (int c = 0; c < hem_pkg::MAX_VERTICES; c++) edge_wt[r][c] = '0;
    end
    vertex_total        = 6'd32;
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.vertex_count = '0;
    in_if.valid         = 1'b0;
    in_if.opcode        = '0;
    in_if.vertex_a      = '0;
    in_if.vertex_b      = '0;
    in_if.edge_weight   = '0;
    out_if.ready        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_weight_extremes();
    test_visit_order();
    test_count_extremes();
    test_output_backpressure();
    test_random_graphs();

    wait_all_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
